// ===== rtl/core/spmc_pkg.sv =====
// Shared constants and types of the spiral prime matrix cell block.
package spmc_pkg;

  localparam int SIEVE_LIMIT = 10000;
  localparam int MAX_SIZE    = 35;
  localparam int TABLE_DEPTH = 1229;

  localparam int SIZE_W = 6;
  localparam int VAL_W  = 14;
  localparam int MAP_W  = $clog2(SIEVE_LIMIT + 1);
  localparam int POS_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } spmc_wr_t;

endpackage

// ===== rtl/core/spiral_prime_matrix_cell_core.sv =====
// Spiral prime matrix cell: returns the prime at a cell's clockwise spiral position.
// After reset the block clears a 10001-entry composite map, marks multiples of each
// prime up to 100 and scans the map into the prime table; in_tready stays low until
// the sieve is done. From then on one beat is taken every cycle while the output is
// not stalled, and each result passes through registered steps in this order: input
// compare, ring minimum, ring base multiply and edge offset, position add, then the
// prime table read. Cells outside the n by n matrix return value 0 with out_of_range
// set. matrix_size saturates at 35 and must be written while idle.
module spiral_prime_matrix_cell_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,     // matrix_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // row [5:0], column [11:6]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // value [13:0]
  output logic        out_tuser      // out_of_range
);

  localparam int SW = spmc_pkg::SIZE_W;
  localparam int PW = spmc_pkg::POS_W;
  localparam int VW = spmc_pkg::VAL_W;

  spmc_pkg::spmc_wr_t          tbl_wr;
  logic [spmc_pkg::CNT_W-1:0]  prime_count;
  logic                        sieve_done;

  logic [VW-1:0] prime_mem [0:spmc_pkg::TABLE_DEPTH-1];

  logic [SW-1:0] size_r;
  logic [SW-1:0] size_sat;
  logic [SW-1:0] in_row;
  logic [SW-1:0] in_col;
  logic          in_oor;

  logic          v1_r, v2_r, v3_r, v4_r, v5_r;
  logic          adv1, adv2, adv3, adv4, adv5;

  logic [SW-1:0] r1_r, c1_r, n1_r;
  logic          oor1_r;
  logic [SW-1:0] r2_r, c2_r, n2_r, lo2_r, hi2_r;
  logic          oor2_r;
  logic [2*SW-1:0] base3_r;
  logic [PW-1:0] off3_r;
  logic          oor3_r;
  logic [PW-1:0] pos4_r;
  logic          oor4_r;
  logic [VW-1:0] q5_r;
  logic          oor5_r;

  logic [SW-1:0] nm1_1, dr1, dc1;
  logic [SW-1:0] ring2, far2, sm1_2, nmr2;
  logic [PW-1:0] off2;
  logic [PW-1:0] pos3;

  spmc_sieve u_sieve (
    .clk         (clk),
    .rst_n       (rst_n),
    .tbl_wr      (tbl_wr),
    .prime_count (prime_count),
    .done        (sieve_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SW'(1);
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  assign adv5 = !v5_r || out_tready;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_tready = sieve_done && adv1;

  assign size_sat = (size_r > SW'(spmc_pkg::MAX_SIZE)) ? SW'(spmc_pkg::MAX_SIZE) : size_r;
  assign in_row   = in_tdata[5:0];
  assign in_col   = in_tdata[11:6];
  assign in_oor   = (size_sat == '0) || (in_row >= size_sat) || (in_col >= size_sat);

  assign nm1_1 = n1_r - 1'b1;
  assign dr1   = nm1_1 - r1_r;
  assign dc1   = nm1_1 - c1_r;

  assign ring2 = (lo2_r < hi2_r) ? lo2_r : hi2_r;
  assign far2  = n2_r - 1'b1 - ring2;
  assign sm1_2 = far2 - ring2;
  assign nmr2  = n2_r - ring2;

  always_comb begin
    if (r2_r == ring2) begin
      off2 = PW'(c2_r - ring2);
    end else if (c2_r == far2) begin
      off2 = PW'(sm1_2) + PW'(r2_r - ring2);
    end else if (r2_r == far2) begin
      off2 = (PW'(sm1_2) << 1) + PW'(far2 - c2_r);
    end else begin
      off2 = (PW'(sm1_2) << 1) + PW'(sm1_2) + PW'(far2 - r2_r);
    end
  end

  assign pos3 = PW'({base3_r, 2'b00}) + off3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid && in_tready;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      r1_r   <= in_row;
      c1_r   <= in_col;
      n1_r   <= size_sat;
      oor1_r <= in_oor;
    end
    if (adv2) begin
      r2_r   <= r1_r;
      c2_r   <= c1_r;
      n2_r   <= n1_r;
      lo2_r  <= (r1_r < c1_r) ? r1_r : c1_r;
      hi2_r  <= (dr1 < dc1) ? dr1 : dc1;
      oor2_r <= oor1_r;
    end
    if (adv3) begin
      base3_r <= ring2 * nmr2;
      off3_r  <= off2;
      oor3_r  <= oor2_r;
    end
    if (adv4) begin
      pos4_r <= pos3;
      oor4_r <= oor3_r || (spmc_pkg::CNT_W'(pos3) >= prime_count);
    end
    if (adv5) begin
      oor5_r <= oor4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_wr.we) begin
      prime_mem[tbl_wr.addr] <= tbl_wr.data;
    end
    if (adv5) begin
      q5_r <= prime_mem[oor4_r ? '0 : pos4_r];
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {2'b00, (oor5_r ? '0 : q5_r)};
  assign out_tuser  = oor5_r;

endmodule

// ===== rtl/core/spmc_sieve.sv =====
// Sieve of Eratosthenes after reset; streams the primes into the prime table.
module spmc_sieve (
  input  logic                    clk,
  input  logic                    rst_n,
  output spmc_pkg::spmc_wr_t      tbl_wr,
  output logic [spmc_pkg::CNT_W-1:0] prime_count,
  output logic                    done
);

  localparam int MW = spmc_pkg::MAP_W;
  localparam int CW = spmc_pkg::CNT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_TEST  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [MW-1:0] LIMIT = MW'(spmc_pkg::SIEVE_LIMIT);

  logic          map_mem [0:spmc_pkg::SIEVE_LIMIT];
  logic          map_q_r;

  logic [2:0]    state_r, state_nxt;
  logic [MW-1:0] addr_r, addr_nxt;
  logic [MW-1:0] base_r, base_nxt;
  logic [MW-1:0] mult_r, mult_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic [MW-1:0] chk_addr_r, chk_addr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [2*MW-1:0] base_sq;
  logic [MW:0]     mult_step;
  logic            map_we;
  logic            map_wd;
  logic [MW-1:0]   map_wa;
  logic            map_re;
  logic [MW-1:0]   map_ra;
  logic            take;

  assign base_sq   = base_r * base_r;
  assign mult_step = {1'b0, mult_r} + {1'b0, base_r};
  assign take      = chk_v_r && !map_q_r && (cnt_r < CW'(spmc_pkg::TABLE_DEPTH));

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    base_nxt     = base_r;
    mult_nxt     = mult_r;
    chk_v_nxt    = 1'b0;
    chk_addr_nxt = chk_addr_r;
    cnt_nxt      = take ? cnt_r + 1'b1 : cnt_r;
    map_we       = 1'b0;
    map_wd       = 1'b0;
    map_wa       = addr_r;
    map_re       = 1'b0;
    map_ra       = base_r;
    case (state_r)
      S_CLEAR: begin
        map_we = 1'b1;
        if (addr_r == LIMIT) begin
          base_nxt  = MW'(2);
          state_nxt = S_READ;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_READ: begin
        if (base_sq > (2*MW)'(spmc_pkg::SIEVE_LIMIT)) begin
          addr_nxt  = MW'(2);
          state_nxt = S_SCAN;
        end else begin
          map_re    = 1'b1;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (!map_q_r) begin
          mult_nxt  = base_sq[MW-1:0];
          state_nxt = S_MARK;
        end else begin
          base_nxt  = base_r + 1'b1;
          state_nxt = S_READ;
        end
      end
      S_MARK: begin
        map_we = 1'b1;
        map_wd = 1'b1;
        map_wa = mult_r;
        if (mult_step > {1'b0, LIMIT}) begin
          base_nxt  = base_r + 1'b1;
          state_nxt = S_READ;
        end else begin
          mult_nxt = mult_step[MW-1:0];
        end
      end
      S_SCAN: begin
        map_re       = 1'b1;
        map_ra       = addr_r;
        chk_v_nxt    = 1'b1;
        chk_addr_nxt = addr_r;
        if (addr_r == LIMIT) begin
          state_nxt = S_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_DONE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_q_r <= map_mem[map_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      base_r  <= '0;
      mult_r  <= '0;
      chk_v_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      base_r  <= base_nxt;
      mult_r  <= mult_nxt;
      chk_v_r <= chk_v_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
  end

  assign tbl_wr.we   = take;
  assign tbl_wr.addr = cnt_r[spmc_pkg::POS_W-1:0];
  assign tbl_wr.data = spmc_pkg::VAL_W'(chk_addr_r);
  assign prime_count = cnt_r;
  assign done        = (state_r == S_DONE);

endmodule
